// ===== src/fps_pkg.sv =====
// shared types and constants of the fenwick prefix sum table
`timescale 1ns / 1ps
package fps_pkg;

  localparam int unsigned IDX_W             = 11;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned DEF_MAX_POSITIONS = 1024;
  localparam logic [IDX_W-1:0] SIZE_RESET   = 11'd1024;

  // register select is paddr bit 2; register 0 is table_size
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_PREFIX = 2'd1,
    OP_RANGE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [IDX_W-1:0]          index;
    logic [IDX_W-1:0]          low_index;
    logic signed [DATA_W-1:0]  delta;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  sum;
    logic                      status;
  } out_item_t;

endpackage

// ===== src/fenwick_prefix_sum_table.sv =====
// top level of the fenwick prefix sum table
`timescale 1ns / 1ps
// binary indexed tree of 32-bit wrapping counters over positions 1..table_size
// input channel (in_valid_i / in_ready_o / in_data_i): one transaction is one
//   operation: update add, prefix query, range query or clear all
// output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
//   transaction per operation, in order, holding sum and status
// apb port: register 0 is table_size; the user writes it only while the block
//   is idle, which the block itself does not enforce
// each tree step reads one tree-store entry (read data registered); an update
//   adds delta to it, a query accumulates it; a range query walks index and
//   then low_index - 1, subtracting; a bad index skips the walk; clear all
//   zeroes every entry; one operation is in flight at a time; the next is
//   taken while the previous result still sits in the output register
// reset: a clearing pass writes zero to all MAX_POSITIONS entries, one per
//   cycle, and in_ready_o stays low until the pass is done
// stall: a result waits in the output register; a following result waits in
//   the done state until the output register frees up
module fenwick_prefix_sum_table import fps_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // address width of the store, width of a position, width of a walk position
  localparam int unsigned AW  = $clog2(MAX_POSITIONS);
  localparam int unsigned PW  = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned PSW = PW + 1;
  localparam int unsigned CW  = (PSW > IDX_W) ? PSW : IDX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  table_size_q;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              clr_resp_q, clr_resp_d;   // sweep came from a clear op
  op_e               op_q, op_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [PSW-1:0]    pos_q, pos_d;
  logic [PSW-1:0]    lo_pos_q, lo_pos_d;        // low_index - 1
  logic              phase_q, phase_d;          // second walk of a range query
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              status_q, status_d;
  logic              rd_pend_q, rd_pend_d;      // read issued last cycle
  logic              rd_neg_q, rd_neg_d;        // pending read subtracts
  logic [AW-1:0]     rd_addr_q, rd_addr_d;      // address of pending read
  logic              out_valid_q;
  out_item_t         out_data_q;

  // memory port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // walk helpers
  logic [CW-1:0]     size_c, ts_c, max_c, hi_c, lo_c, pos_c;
  logic [PSW-1:0]    pos_m1, low_bit;
  logic              walk_active, in_fire, out_load;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(table_size_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE)) begin
      table_size_q <= pwdata[IDX_W-1:0];
    end
  end

  // effective size saturates at the store depth
  assign ts_c   = CW'(table_size_q);
  assign max_c  = CW'(MAX_POSITIONS);
  assign size_c = (ts_c > max_c) ? max_c : ts_c;
  assign hi_c   = CW'(in_data_i.index);
  assign lo_c   = CW'(in_data_i.low_index);
  assign pos_c  = CW'(pos_q);

  // ---------------------------------------------------------------------
  // tree walk
  // ---------------------------------------------------------------------
  assign pos_m1  = pos_q - PSW'(1);
  assign low_bit = pos_q & (~pos_q + PSW'(1));

  // update climbs while inside the table, queries descend to zero
  assign walk_active = (op_q == OP_UPDATE) ? ((pos_q != '0) && (pos_c <= size_c))
                                           : (pos_q != '0);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_resp_d = clr_resp_q;
    op_d       = op_q;
    delta_d    = delta_q;
    pos_d      = pos_q;
    lo_pos_d   = lo_pos_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    status_d   = status_q;
    rd_pend_d  = 1'b0;
    rd_neg_d   = rd_neg_q;
    rd_addr_d  = rd_addr_q;
    ram_we     = 1'b0;
    ram_waddr  = rd_addr_q;
    ram_wdata  = ram_rdata + delta_q;
    ram_re     = 1'b0;
    ram_raddr  = pos_m1[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d     = in_data_i.op;
          delta_d  = in_data_i.delta;
          pos_d    = PSW'(in_data_i.index);
          lo_pos_d = PSW'(in_data_i.low_index - IDX_W'(1));
          phase_d  = 1'b0;
          acc_d    = '0;
          status_d = STATUS_OK;
          if (in_data_i.op == OP_CLEAR) begin
            clr_cnt_d  = '0;
            clr_resp_d = 1'b1;
            state_d    = ST_CLR;
          end else if ((hi_c == '0) || (hi_c > size_c) ||
                       ((in_data_i.op == OP_RANGE) &&
                        ((lo_c == '0) || (lo_c > hi_c)))) begin
            status_d = STATUS_BAD;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MAX_POSITIONS - 1)) begin
          state_d = clr_resp_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_WALK: begin
        // retire the read issued last cycle
        if (rd_pend_q) begin
          if (op_q == OP_UPDATE) begin
            ram_we = 1'b1;
          end else begin
            acc_d = rd_neg_q ? (acc_q - ram_rdata) : (acc_q + ram_rdata);
          end
        end
        // issue the next step
        if (walk_active) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_neg_d  = phase_q;
          rd_addr_d = pos_m1[AW-1:0];
          pos_d     = (op_q == OP_UPDATE) ? (pos_q + low_bit) : (pos_q - low_bit);
        end else if ((op_q == OP_RANGE) && !phase_q) begin
          pos_d   = lo_pos_q;
          phase_d = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          clr_resp_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      clr_resp_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_resp_q <= clr_resp_d;
      rd_pend_q  <= rd_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    delta_q   <= delta_d;
    pos_q     <= pos_d;
    lo_pos_q  <= lo_pos_d;
    phase_q   <= phase_d;
    acc_q     <= acc_d;
    status_q  <= status_d;
    rd_neg_q  <= rd_neg_d;
    rd_addr_q <= rd_addr_d;
    if (out_load) begin
      out_data_q.sum    <= acc_q;
      out_data_q.status <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  fps_ram #(
    .DEPTH (MAX_POSITIONS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // an update walk only writes entries inside the table
  a_walk_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == ST_WALK)) |-> (CW'(ram_waddr) < size_c))
    else $error("update wrote beyond table size");

  // queries never modify the store
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && (op_q != OP_UPDATE)) |-> !ram_we)
    else $error("query wrote the store");

  // a flagged result carries a zero sum
  a_bad_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STATUS_BAD)) |-> (out_data_o.sum == '0))
    else $error("flagged result with nonzero sum");

  // the sweep ends after the last entry
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLR) && (clr_cnt_q == AW'(MAX_POSITIONS - 1))) |=> (state_q != ST_CLR))
    else $error("clearing pass did not end");

  // no read is left in flight when a new operation can enter
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_pend_q)
    else $error("read pending while idle");
`endif

endmodule

// ===== src/fps_ram.sv =====
// tree store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module fps_ram import fps_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_POSITIONS,
  parameter int unsigned AW    = $clog2(DEF_MAX_POSITIONS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== test/tb_fenwick_prefix_sum_table.sv =====
// testbench for the fenwick prefix sum table: directed table plus random operations
`timescale 1ns / 1ps
module tb_fenwick_prefix_sum_table;
  import fps_pkg::*;

  localparam int unsigned MAX_POS        = DEF_MAX_POSITIONS;
  localparam int unsigned RESET_CYCLES   = 5;
  // a clear walks every entry, so long quiet stretches are legal
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = MAX_POS + 100;
  localparam int unsigned PHASE_ITEMS    = 220;
  localparam int unsigned NUM_PHASES     = 8;
  localparam logic [2:0]  ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
  localparam logic [2:0]  ADDR_UNMAPPED   = {~REG_TABLE_SIZE, 2'b00};

  typedef struct packed {
    in_item_t  item;
    logic      typed;   // want holds a hand-written result
    out_item_t want;
  } directed_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // mirror of the block: tree entries and the size register
  logic [DATA_W-1:0] tree_model [1:MAX_POS];
  logic [IDX_W-1:0]  size_reg;

  out_item_t     awaited_results [$];
  directed_row_t directed_rows [$];
  int unsigned   error_count    = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   sink_stall_pct = 0;

  fenwick_prefix_sum_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned lowest_bit(input int unsigned x);
    return x & (~x + 1);
  endfunction

  // downward walk: sum of positions 1..pos
  function automatic logic [DATA_W-1:0] tree_prefix(input int unsigned pos);
    logic [DATA_W-1:0] acc;
    acc = '0;
    while (pos != 0) begin
      if (pos <= MAX_POS) acc += tree_model[pos];
      pos -= lowest_bit(pos);
    end
    return acc;
  endfunction

  // applies one operation to the mirror and returns its result
  function automatic out_item_t apply_operation(input in_item_t it);
    out_item_t   res;
    int unsigned eff;
    int unsigned hi;
    int unsigned lo;
    int unsigned pos;
    res.sum    = '0;
    res.status = STATUS_OK;
    // sizes beyond the store saturate, zero disables every position
    eff = (size_reg > MAX_POS) ? MAX_POS : size_reg;
    hi  = it.index;
    lo  = it.low_index;
    if (it.op == OP_CLEAR) begin
      for (int p = 1; p <= MAX_POS; p++) tree_model[p] = '0;
    end else if (hi == 0 || hi > eff) begin
      res.status = STATUS_BAD;
    end else if (it.op == OP_UPDATE) begin
      // upward walk stops at the current size, so entries above it go stale
      pos = hi;
      while (pos != 0 && pos <= eff) begin
        tree_model[pos] += it.delta;
        pos += lowest_bit(pos);
      end
    end else if (it.op == OP_PREFIX) begin
      res.sum = tree_prefix(hi);
    end else if (lo == 0 || lo > hi) begin
      res.status = STATUS_BAD;
    end else begin
      res.sum = tree_prefix(hi) - tree_prefix(lo - 1);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // only register 0 exists, other addresses are dropped
    if (addr == ADDR_TABLE_SIZE) size_reg = data[IDX_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_size_readback();
    logic [31:0] data;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TABLE_SIZE;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== {{(32-IDX_W){1'b0}}, size_reg})
      report_mismatch("table_size readback", data, {{(32-IDX_W){1'b0}}, size_reg});
  endtask

  // ---------------------------------------------------------------------------
  // input channel
  // ---------------------------------------------------------------------------

  // drives one operation, predicts its result once the transaction is taken
  task automatic send_op(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_operation(it);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
  endtask

  // sender holds off until every result is back, the block is then idle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input op_e op, input int unsigned idx, input int unsigned lo,
                         input logic [31:0] delta, input logic typed,
                         input logic status);
    directed_row_t row;
    row.item.op        = op;
    row.item.index     = idx[IDX_W-1:0];
    row.item.low_index = lo[IDX_W-1:0];
    row.item.delta     = delta;
    row.typed          = typed;
    row.want.sum       = '0;
    row.want.status    = status;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic in_item_t random_item(input int unsigned eff);
    in_item_t    it;
    int unsigned pick;
    int unsigned hi;
    int unsigned lo;
    pick = $urandom_range(99);
    if (pick < 1)       it.op = OP_CLEAR;
    else if (pick < 41) it.op = OP_UPDATE;
    else if (pick < 66) it.op = OP_PREFIX;
    else                it.op = OP_RANGE;
    // mostly valid positions, some noise and some edges
    pick = $urandom_range(99);
    if (eff == 0 || pick < 8) begin
      hi = $urandom_range(2047);
    end else if (pick < 14) begin
      case ($urandom_range(3))
        0:       hi = 0;
        1:       hi = 1;
        2:       hi = eff;
        default: hi = eff + 1;
      endcase
    end else begin
      hi = $urandom_range(eff, 1);
    end
    it.index = hi[IDX_W-1:0];
    pick = $urandom_range(99);
    if (it.op != OP_RANGE || pick < 10) lo = $urandom_range(2047);
    else if (pick < 13)                  lo = 0;
    else if (pick < 16)                  lo = hi + 1;
    else                                 lo = (hi == 0) ? 0 : $urandom_range(hi, 1);
    it.low_index = lo[IDX_W-1:0];
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0:       it.delta = 32'h7fff_ffff;
        1:       it.delta = 32'h8000_0000;
        2:       it.delta = 32'hffff_ffff;
        default: it.delta = '0;
      endcase
    end else if (pick < 50) begin
      it.delta = int'($urandom_range(200)) - 100;
    end else begin
      it.delta = $urandom;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // output channel: random stalls and in-order checking
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_data_o.sum, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.sum !== want.sum)
          report_mismatch("sum", out_data_o.sum, want.sum);
        if (out_data_o.status !== want.status)
          report_mismatch("status", {31'b0, out_data_o.status}, {31'b0, want.status});
      end
    end
  end

  // no transaction on either channel for too long means a hang
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("fenwick_prefix_sum_table: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned eff;
    int unsigned new_size;
    out_item_t   no_result;
    no_result = '0;
    for (int p = 1; p <= MAX_POS; p++) tree_model[p] = '0;
    size_reg = SIZE_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_size_readback();

    // directed part at the reset size
    add_row(OP_PREFIX, 1024, 0,    32'h0,         1'b1, STATUS_OK);  // empty store
    add_row(OP_UPDATE, 0,    0,    32'h1,         1'b1, STATUS_BAD); // position zero
    add_row(OP_UPDATE, 1025, 0,    32'h1,         1'b1, STATUS_BAD); // above size
    add_row(OP_PREFIX, 0,    0,    32'h0,         1'b1, STATUS_BAD);
    add_row(OP_RANGE,  5,    0,    32'h0,         1'b1, STATUS_BAD); // low bound zero
    add_row(OP_RANGE,  5,    6,    32'h0,         1'b1, STATUS_BAD); // low above high
    add_row(OP_RANGE,  2047, 1,    32'h0,         1'b1, STATUS_BAD);
    add_row(OP_UPDATE, 1,    2047, 32'h7fff_ffff, 1'b1, STATUS_OK);
    add_row(OP_UPDATE, 1024, 0,    32'h8000_0000, 1'b1, STATUS_OK);
    add_row(OP_UPDATE, 1,    0,    32'h1,         1'b1, STATUS_OK);  // wraps position 1
    add_row(OP_PREFIX, 1,    0,    32'h0,         1'b0, STATUS_OK);
    add_row(OP_PREFIX, 1024, 0,    32'h0,         1'b0, STATUS_OK);
    add_row(OP_RANGE,  1024, 1,    32'h0,         1'b0, STATUS_OK);
    add_row(OP_RANGE,  1024, 1024, 32'h0,         1'b0, STATUS_OK);
    add_row(OP_UPDATE, 1023, 0,    32'hffff_ffff, 1'b1, STATUS_OK);
    add_row(OP_UPDATE, 512,  0,    32'h1234_5678, 1'b1, STATUS_OK);
    add_row(OP_RANGE,  7,    7,    32'h0,         1'b0, STATUS_OK);
    add_row(OP_PREFIX, 1023, 0,    32'h0,         1'b0, STATUS_OK);
    add_row(OP_RANGE,  1023, 513,  32'h0,         1'b0, STATUS_OK);
    add_row(OP_CLEAR,  2047, 2047, 32'hffff_ffff, 1'b1, STATUS_OK);  // clear ignores fields
    add_row(OP_PREFIX, 1024, 0,    32'h0,         1'b1, STATUS_OK);  // cleared store
    add_row(OP_UPDATE, 2047, 2047, 32'h5,         1'b1, STATUS_BAD);
    send_idle_pct  = 12;
    sink_stall_pct = 12;
    foreach (directed_rows[i])
      send_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // a write to an address with no register leaves table_size alone
    apb_write(ADDR_UNMAPPED, 32'd5);
    check_size_readback();

    // random phases, each with its own size; the idling pattern rotates through four settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin send_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      case (phase)
        0:       new_size = 1024;
        1:       new_size = 1;
        2:       new_size = 2047;  // saturates to the store depth
        3:       new_size = 37;    // smaller size leaves stale upper entries
        4:       new_size = 0;     // every position is invalid
        5:       new_size = 2;
        6:       new_size = 1000;
        default: new_size = $urandom_range(1024, 1);
      endcase
      apb_write(ADDR_TABLE_SIZE, new_size);
      check_size_readback();
      eff = (size_reg > MAX_POS) ? MAX_POS : size_reg;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // in the first phase only, hold off once mid-phase until the block has caught up
        if (phase == 0 && n == PHASE_ITEMS / 2) drain_results();
        send_op(random_item(eff), 1'b0, no_result);
      end
      drain_results();
    end

    // let any late or spurious result show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("fenwick_prefix_sum_table: match");
    end else begin
      $display("fenwick_prefix_sum_table: mismatch");
    end
    $finish;
  end

endmodule
